// ===== hdl/ppgbd_pkg.sv =====
// ppgbd_pkg: shared types and constants of the ppg envelope beat detector
// sequencer state codes, register indexes, reset values and fixed-point constants
// no dependencies
package ppgbd_pkg;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int DIV_W = 32;
    localparam int DIV_CNT_W = 5;
    localparam int LEVEL_W = 17;
    localparam int LEVEL_STEPS = 17;
    localparam int RATE_STEPS = 16;
    localparam int FRAC_BITS = 8;
    localparam int DECAY_SHIFT = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int RAW_W = 18;
    localparam int TIME_W = 32;
    localparam int BPM_W = 8;
    localparam int RATE_OUT_W = 10;

    localparam logic [15:0] RATE_DIVIDEND = 16'd60000;
    localparam logic [LEVEL_W-1:0] HALF_LEVEL = 17'd32768;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;
    localparam logic [RATE_OUT_W-1:0] RATE_SUM_MAX = 10'd1023;

    localparam logic [15:0] ENV_DECAY_RST = 16'd65208;
    localparam logic [19:0] MIN_AMP_RST = 20'd16;
    localparam logic [16:0] SYSTOLIC_RST = 17'd39322;
    localparam logic [16:0] DIASTOLIC_RST = 17'd26214;
    localparam logic [17:0] FINGER_RST = 18'd5000;
    localparam logic [7:0] MIN_BPM_RST = 8'd20;
    localparam logic [7:0] MAX_BPM_RST = 8'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ENV_DECAY = 3'd0,
        CFG_MIN_AMP = 3'd1,
        CFG_SYSTOLIC = 3'd2,
        CFG_DIASTOLIC = 3'd3,
        CFG_FINGER = 3'd4,
        CFG_MIN_BPM = 3'd5,
        CFG_MAX_BPM = 3'd6
    } cfg_idx_t;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_PEAK_MUL = 13'b0000000000010,
        S_PEAK_UPD = 13'b0000000000100,
        S_VAL_MUL = 13'b0000000001000,
        S_VAL_UPD = 13'b0000000010000,
        S_SPAN = 13'b0000000100000,
        S_DIV = 13'b0000001000000,
        S_BEAT = 13'b0000010000000,
        S_LO_MUL = 13'b0000100000000,
        S_HI_MUL = 13'b0001000000000,
        S_RATE_CHK = 13'b0010000000000,
        S_RING = 13'b0100000000000,
        S_OUT = 13'b1000000000000
    } state_t;

endpackage

// ===== hdl/ppg_envelope_beat_detector.sv =====
// ppg_envelope_beat_detector: envelope tracking, normalizing, beat and heart rate averaging
// depends on ppgbd_pkg; one shared 32x16 multiplier and one shared 33-bit divider step
// A word is taken on s_valid/s_ready and gives one result word on m_valid/m_ready. The block
// works on one word at a time and holds a finished result while the previous result still
// waits for m_ready. A 32x16 multiplier scales the envelopes and checks the rate bounds, and
// a shared compare-subtract divider that produces one quotient bit per cycle normalizes the
// sample and, on an accepted beat, forms 60000/interval. A finished result waits in the output
// register while the next word is already taken.
// Configuration writes are meant for an idle block.
module ppg_envelope_beat_detector
    import ppgbd_pkg::*;
#(
    parameter int RATE_SLOTS = 4,
    parameter int AC_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [AC_BITS-1:0]    s_ac_sample,
    input  logic [RAW_W-1:0]             s_raw_ir,
    input  logic [TIME_W-1:0]            s_time_ms,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [LEVEL_W-1:0]           m_level,
    output logic                         m_beat,
    output logic [RATE_OUT_W-1:0]        m_rate_quarter_bpm,
    output logic                         m_finger_detect
);

    localparam int ENV_W = AC_BITS + FRAC_BITS;
    localparam int SLOT_W = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;
    localparam int SUM_RAW_W = BPM_W + $clog2(RATE_SLOTS);
    localparam int SUM_W = (SUM_RAW_W > RATE_OUT_W) ? SUM_RAW_W : RATE_OUT_W;

    state_t state_reg;

    logic [15:0] env_decay_reg;
    logic [19:0] min_amp_reg;
    logic [16:0] systolic_reg;
    logic [16:0] diastolic_reg;
    logic [17:0] finger_level_reg;
    logic [7:0]  min_bpm_reg;
    logic [7:0]  max_bpm_reg;

    logic signed [ENV_W-1:0] ac_reg;
    logic [TIME_W-1:0]       time_reg;
    logic                    finger_reg;
    logic signed [ENV_W-1:0] peak_reg;
    logic signed [ENV_W-1:0] valley_reg;
    logic                    above_reg;
    logic [TIME_W-1:0]       last_time_reg;
    logic                    last_valid_reg;
    logic [BPM_W-1:0]        ring_reg [RATE_SLOTS];
    logic [SLOT_W-1:0]       slot_reg;
    logic [SUM_W-1:0]        sum_reg;

    logic [PROD_W-1:0]    prod_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     divisor_reg;
    logic [15:0]          dvd_reg;
    logic [LEVEL_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 div_first_reg;
    logic                 div_rate_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 beat_reg;
    logic [TIME_W-1:0]    d_reg;
    logic                 lo_ok_reg;

    logic                 m_valid_reg;
    logic [LEVEL_W-1:0]   m_level_reg;
    logic                 m_beat_reg;
    logic [RATE_OUT_W-1:0] m_rate_reg;
    logic                 m_finger_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;

    logic [ENV_W-1:0]        peak_mag;
    logic [ENV_W-1:0]        valley_mag;
    logic [ENV_W-1:0]        dec_mag;
    logic signed [ENV_W-1:0] dec_pos;
    logic signed [ENV_W-1:0] peak_next;
    logic signed [ENV_W-1:0] valley_next;
    logic signed [ENV_W:0]   span_s;
    logic signed [ENV_W:0]   num_s;
    logic                    span_small;

    logic [DIV_W:0]       div_t;
    logic [DIV_W:0]       div_diff;
    logic                 div_ge;
    logic [DIV_W-1:0]     rem_next;
    logic [LEVEL_W-1:0]   quo_next;

    logic                 beat_cond;
    logic [TIME_W-1:0]    d_next;
    logic [SLOT_W-1:0]    slot_next;
    logic [SUM_W-1:0]     sum_next;
    logic [RATE_OUT_W-1:0] rate_sat;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;
    assign m_beat = m_beat_reg;
    assign m_rate_quarter_bpm = m_rate_reg;
    assign m_finger_detect = m_finger_reg;

    // magnitude and decay
    assign peak_mag = peak_reg[ENV_W-1] ? ENV_W'(-peak_reg) : peak_reg;
    assign valley_mag = valley_reg[ENV_W-1] ? ENV_W'(-valley_reg) : valley_reg;
    assign dec_mag = prod_reg[DECAY_SHIFT +: ENV_W];
    assign dec_pos = $signed(dec_mag);
    assign peak_next = (ac_reg > peak_reg) ? ac_reg
                     : (peak_reg[ENV_W-1] ? -dec_pos : dec_pos);
    assign valley_next = (ac_reg < valley_reg) ? ac_reg
                       : (valley_reg[ENV_W-1] ? -dec_pos : dec_pos);

    // span and numerator of the normalizing division
    assign span_s = {peak_reg[ENV_W-1], peak_reg} - {valley_reg[ENV_W-1], valley_reg};
    assign num_s = {ac_reg[ENV_W-1], ac_reg} - {valley_reg[ENV_W-1], valley_reg};
    assign span_small = span_s[ENV_W] || (span_s == '0)
                     || (33'(span_s[ENV_W-1:0]) < 33'({min_amp_reg, 8'h00}));

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PEAK_MUL: begin
                mul_a = MUL_A_W'(peak_mag);
                mul_b = env_decay_reg;
            end
            S_VAL_MUL: begin
                mul_a = MUL_A_W'(valley_mag);
                mul_b = env_decay_reg;
            end
            S_LO_MUL: begin
                mul_a = d_reg;
                mul_b = {8'h00, min_bpm_reg};
            end
            S_HI_MUL: begin
                mul_a = d_reg;
                mul_b = {8'h00, max_bpm_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_prod = mul_a * mul_b;

    // shared divider step
    assign div_t = div_first_reg ? {1'b0, rem_reg} : {rem_reg, dvd_reg[15]};
    assign div_diff = div_t - {1'b0, divisor_reg};
    assign div_ge = (div_t >= {1'b0, divisor_reg});
    assign rem_next = div_ge ? div_diff[DIV_W-1:0] : div_t[DIV_W-1:0];
    assign quo_next = {quo_reg[LEVEL_W-2:0], div_ge};

    // beat and rate ring
    assign beat_cond = (level_reg > systolic_reg) && !above_reg;
    assign d_next = time_reg - last_time_reg;
    assign slot_next = (slot_reg == SLOT_W'(RATE_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    assign sum_next = sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(quo_reg[BPM_W-1:0]);
    assign rate_sat = (sum_reg > SUM_W'(RATE_SUM_MAX)) ? RATE_SUM_MAX
                    : sum_reg[RATE_OUT_W-1:0];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            env_decay_reg <= ENV_DECAY_RST;
            min_amp_reg <= MIN_AMP_RST;
            systolic_reg <= SYSTOLIC_RST;
            diastolic_reg <= DIASTOLIC_RST;
            finger_level_reg <= FINGER_RST;
            min_bpm_reg <= MIN_BPM_RST;
            max_bpm_reg <= MAX_BPM_RST;
            peak_reg <= '0;
            valley_reg <= '0;
            above_reg <= 1'b0;
            last_time_reg <= '0;
            last_valid_reg <= 1'b0;
            for (int i = 0; i < RATE_SLOTS; i++) begin
                ring_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_addr)
                    CFG_ENV_DECAY: env_decay_reg <= cfg_wdata[15:0];
                    CFG_MIN_AMP: min_amp_reg <= cfg_wdata[19:0];
                    CFG_SYSTOLIC: systolic_reg <= cfg_wdata[16:0];
                    CFG_DIASTOLIC: diastolic_reg <= cfg_wdata[16:0];
                    CFG_FINGER: finger_level_reg <= cfg_wdata[17:0];
                    CFG_MIN_BPM: min_bpm_reg <= cfg_wdata[7:0];
                    CFG_MAX_BPM: max_bpm_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_PEAK_MUL;
                    end
                end
                S_PEAK_MUL: state_reg <= S_PEAK_UPD;
                S_PEAK_UPD: begin
                    peak_reg <= peak_next;
                    state_reg <= S_VAL_MUL;
                end
                S_VAL_MUL: state_reg <= S_VAL_UPD;
                S_VAL_UPD: begin
                    valley_reg <= valley_next;
                    state_reg <= S_SPAN;
                end
                S_SPAN: begin
                    if (span_small || num_s[ENV_W] || (num_s == '0) || (num_s >= span_s)) begin
                        state_reg <= S_BEAT;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_cnt_reg == '0) begin
                        state_reg <= div_rate_reg ? S_RING : S_BEAT;
                    end
                end
                S_BEAT: begin
                    if (beat_cond) begin
                        above_reg <= 1'b1;
                        last_time_reg <= time_reg;
                        last_valid_reg <= 1'b1;
                        if (last_valid_reg && (d_next != '0)) begin
                            state_reg <= S_LO_MUL;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end else begin
                        if (level_reg <= diastolic_reg) begin
                            above_reg <= 1'b0;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_LO_MUL: state_reg <= S_HI_MUL;
                S_HI_MUL: state_reg <= S_RATE_CHK;
                S_RATE_CHK: begin
                    if (lo_ok_reg && (prod_reg >= PROD_W'(RATE_DIVIDEND))) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_RING: begin
                    ring_reg[slot_reg] <= quo_reg[BPM_W-1:0];
                    slot_reg <= slot_next;
                    sum_reg <= sum_next;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_prod;
        unique case (state_reg)
            S_IDLE: begin
                ac_reg <= {s_ac_sample, 8'h00};
                time_reg <= s_time_ms;
                finger_reg <= (s_raw_ir > finger_level_reg);
            end
            S_SPAN: begin
                level_reg <= span_small ? HALF_LEVEL
                           : ((num_s >= span_s) ? LEVEL_ONE : '0);
                rem_reg <= DIV_W'(num_s[ENV_W-1:0]);
                divisor_reg <= DIV_W'(span_s[ENV_W-1:0]);
                dvd_reg <= '0;
                quo_reg <= '0;
                div_first_reg <= 1'b1;
                div_rate_reg <= 1'b0;
                div_cnt_reg <= DIV_CNT_W'(LEVEL_STEPS - 1);
            end
            S_DIV: begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                dvd_reg <= {dvd_reg[14:0], 1'b0};
                div_first_reg <= 1'b0;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if ((div_cnt_reg == '0) && !div_rate_reg) begin
                    level_reg <= quo_next;
                end
            end
            S_BEAT: begin
                beat_reg <= beat_cond;
                d_reg <= d_next;
            end
            S_HI_MUL: begin
                lo_ok_reg <= (prod_reg <= PROD_W'(RATE_DIVIDEND));
            end
            S_RATE_CHK: begin
                rem_reg <= '0;
                divisor_reg <= d_reg;
                dvd_reg <= RATE_DIVIDEND;
                quo_reg <= '0;
                div_first_reg <= 1'b0;
                div_rate_reg <= 1'b1;
                div_cnt_reg <= DIV_CNT_W'(RATE_STEPS - 1);
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_level_reg <= level_reg;
                    m_beat_reg <= beat_reg;
                    m_rate_reg <= rate_sat;
                    m_finger_reg <= finger_reg;
                end
            end
            default: ;
        endcase
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block took a second word while busy");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_cnt_reg <= DIV_CNT_W'(LEVEL_STEPS - 1)))
        else $error("divider step count out of range");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_W'(RATE_SLOTS * 255))
        else $error("rate ring sum exceeds slot bound");

    a_beat_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) && beat_reg |-> above_reg)
        else $error("beat given without the above flag set");

endmodule
